// ===== rtl/oaht_pkg.sv =====
// Shared types and constants for the open-addressing hash table unit.
package oaht_pkg;

    localparam int unsigned SLOTS_DEFAULT     = 1024;
    localparam int unsigned KEY_BYTES_DEFAULT = 8;
    localparam int unsigned MIN_SLOTS         = 16;
    localparam int unsigned CNT_W             = 11;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_MULT  = 32'd16777619;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_LIVE  = 2'd1;
    localparam logic [1:0] MARK_DEAD  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key_bytes;
        logic [3:0]  key_length;
        logic        key_absent;
        logic [63:0] new_value;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [63:0]      read_value;
        logic [CNT_W-1:0] live_count;
        logic [CNT_W-1:0] dead_count;
        logic             grow_advised;
    } t_rsp;

endpackage

// ===== rtl/oaht_hash.sv =====
// Byte-serial FNV-1a hash unit, one key byte per cycle.
module oaht_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_key,
    input  logic [3:0]  i_len,
    output logic        o_done,
    output logic [31:0] o_hash
);

    logic        r_busy, n_busy;
    logic [63:0] r_key, n_key;
    logic [3:0]  r_left, n_left;
    logic [31:0] r_hash, n_hash;
    logic        r_done, n_done;
    logic [31:0] w_x;
    logic [31:0] w_prod;

    assign w_x    = r_hash ^ {24'd0, r_key[7:0]};
    assign w_prod = w_x * oaht_pkg::FNV_MULT;

    always_comb begin
        n_busy = r_busy;
        n_key  = r_key;
        n_left = r_left;
        n_hash = r_hash;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_key  = i_key;
            n_left = i_len;
            n_hash = oaht_pkg::FNV_BASIS;
        end else if (r_busy) begin
            if (r_left == 4'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_hash = w_prod;
                n_key  = {8'd0, r_key[63:8]};
                n_left = r_left - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_key  <= n_key;
        r_left <= n_left;
        r_hash <= n_hash;
    end

    assign o_done = r_done;
    assign o_hash = r_hash;

endmodule

// ===== rtl/oaht_mod.sv =====
// Iterative modulo unit: hash reduced by the active slot count, one bit per cycle.
module oaht_mod #(
    parameter int unsigned IDX_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [31:0]      i_num,
    input  logic [IDX_W:0]   i_div,
    output logic             o_done,
    output logic [IDX_W-1:0] o_rem
);

    logic           r_busy, n_busy;
    logic [5:0]     r_cnt, n_cnt;
    logic [31:0]    r_num, n_num;
    logic [IDX_W:0] r_rem, n_rem;
    logic           r_done, n_done;
    logic [IDX_W+1:0] w_sh;

    assign w_sh = {r_rem, r_num[31]};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd32;
            n_num  = i_num;
            n_rem  = '0;
        end else if (r_busy) begin
            n_num = {r_num[30:0], 1'b0};
            if (w_sh >= {1'b0, i_div}) begin
                n_rem = (IDX_W+1)'(w_sh - {1'b0, i_div});
            end else begin
                n_rem = (IDX_W+1)'(w_sh);
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[IDX_W-1:0];

endmodule

// ===== rtl/oaht_store.sv =====
// Slot memories: mark store emptied by a sweep and entry payload store.
module oaht_store #(
    parameter int unsigned SLOTS = 1024,
    parameter int unsigned IDX_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    output logic             o_sweeping,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [1:0]       o_rmark,
    output logic [63:0]      o_rkey,
    output logic [3:0]       o_rlen,
    output logic             o_rnull,
    output logic [31:0]      o_rhash,
    output logic [63:0]      o_rvalue,
    input  logic             i_mwe,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [1:0]       i_wmark,
    input  logic             i_ewe,
    input  logic [63:0]      i_wkey,
    input  logic [3:0]       i_wlen,
    input  logic             i_wnull,
    input  logic [31:0]      i_whash,
    input  logic             i_vwe,
    input  logic [63:0]      i_wvalue
);

    logic [1:0]   mem_mark [SLOTS];
    logic [100:0] mem_ent  [SLOTS];
    logic [63:0]  mem_val  [SLOTS];
    logic [1:0]   r_mrd;
    logic [100:0] r_erd;
    logic [63:0]  r_vrd;
    logic [IDX_W:0] r_sweep;
    logic           r_sweeping;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep    <= '0;
            r_sweeping <= 1'b1;
        end else if (i_clear) begin
            r_sweep    <= '0;
            r_sweeping <= 1'b1;
        end else if (r_sweeping) begin
            r_sweep <= r_sweep + 1'b1;
            if (r_sweep == (IDX_W+1)'(SLOTS - 1)) r_sweeping <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sweeping) begin
            mem_mark[r_sweep[IDX_W-1:0]] <= oaht_pkg::MARK_EMPTY;
        end else if (i_mwe) begin
            mem_mark[i_waddr] <= i_wmark;
        end
        r_mrd <= mem_mark[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ewe) mem_ent[i_waddr] <= {i_wkey, i_wlen, i_wnull, i_whash};
        r_erd <= mem_ent[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_vwe) mem_val[i_waddr] <= i_wvalue;
        r_vrd <= mem_val[i_raddr];
    end

    assign o_sweeping = r_sweeping;
    assign o_rmark  = r_mrd;
    assign o_rkey   = r_erd[100:37];
    assign o_rlen   = r_erd[36:33];
    assign o_rnull  = r_erd[32];
    assign o_rhash  = r_erd[31:0];
    assign o_rvalue = r_vrd;

endmodule

// ===== rtl/open_addressing_hash_table_unit.sv =====
// Top level of the open-addressing hash table unit: request sequencer and probe walk.
// Usage:
// One request transfers on the input channel (i_in_valid high, o_in_stall low),
// and exactly one result transfers on the output channel later, in order.
// Each lookup, insert or remove hashes its key one byte per cycle, reduces the
// hash modulo the active slot count with a bit-serial divider, then walks the
// slot memories one slot at a time (read, then compare) until a hit, an empty
// slot or a full lap. The next request is taken once the result has moved to
// the output register. One request is in flight at a time.
// A clear-all hashes its key, then empties the slot-mark memory with a sweep over
// all SLOTS slots, with o_in_stall high while the sweep runs.
// Reset runs the same sweep; totals clear at once and active slots reset to 16.
// The result waits in an output register while i_out_stall is high; the next
// request is taken meanwhile and held in its last stage until the output frees.
// i_cfg_we writes active slots; write it only while idle and follow with a clear.
module open_addressing_hash_table_unit #(
    parameter int unsigned SLOTS     = oaht_pkg::SLOTS_DEFAULT,
    parameter int unsigned KEY_BYTES = oaht_pkg::KEY_BYTES_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [10:0]     i_cfg_wdata,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  oaht_pkg::t_req  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output oaht_pkg::t_rsp  o_out_data
);

    localparam int unsigned IDX_W  = $clog2(SLOTS);
    localparam int unsigned CNT_W  = oaht_pkg::CNT_W;
    localparam int unsigned MAXLEN = (KEY_BYTES < 8) ? KEY_BYTES : 8;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HASH  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [10:0]      r_active;
    logic [IDX_W:0]   r_n;
    logic [1:0]       r_act;
    logic [63:0]      r_key;
    logic [3:0]       r_len;
    logic             r_null;
    logic [63:0]      r_val;
    logic [31:0]      r_h;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W:0]   r_steps;
    logic             r_have_dead;
    logic [IDX_W-1:0] r_dead_at;
    logic [CNT_W-1:0] r_live, r_dead;
    logic             r_ovalid;
    oaht_pkg::t_rsp   r_out;
    oaht_pkg::t_rsp   r_res;

    logic [10:0]      w_n_clamp;
    logic [3:0]       w_len;
    logic [63:0]      w_key;
    logic [63:0]      w_mask;
    logic             w_accept;
    logic             w_hdone, w_mdone;
    logic [31:0]      w_hash;
    logic [IDX_W-1:0] w_home;
    logic [1:0]       w_rmark;
    logic [63:0]      w_rkey, w_rvalue;
    logic [3:0]       w_rlen;
    logic             w_rnull;
    logic [31:0]      w_rhash;
    logic             w_hit, w_empty, w_last;
    logic             w_use_dead;
    logic [IDX_W-1:0] w_dead_slot;
    logic [IDX_W-1:0] w_raddr, w_next;
    logic [IDX_W:0]   w_next_wide;
    logic             w_clear, w_mwe, w_ewe, w_vwe;
    logic             w_sweeping;
    logic [IDX_W-1:0] w_waddr;
    logic [1:0]       w_wmark;
    logic             w_fin;
    oaht_pkg::t_rsp   w_rsp;
    logic [CNT_W-1:0] w_live_n, w_dead_n;
    logic [CNT_W+3:0] w_lhs, w_rhs;

    always_comb begin
        w_n_clamp = r_active;
        if (r_active < 11'(oaht_pkg::MIN_SLOTS)) w_n_clamp = 11'(oaht_pkg::MIN_SLOTS);
        if ({21'd0, w_n_clamp} > 32'(SLOTS)) w_n_clamp = 11'(SLOTS);
    end

    always_comb begin
        w_len = i_in_data.key_length;
        if (w_len > 4'(MAXLEN)) w_len = 4'(MAXLEN);
        if (i_in_data.key_absent) w_len = 4'd0;
        w_mask = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < w_len) w_mask[b*8 +: 8] = 8'hFF;
        end
        w_key = i_in_data.key_bytes & w_mask;
    end

    assign o_in_stall = (r_state != S_IDLE) || w_sweeping;
    assign w_accept   = i_in_valid && !o_in_stall;

    oaht_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_key   (w_key),
        .i_len   (w_len),
        .o_done  (w_hdone),
        .o_hash  (w_hash)
    );

    oaht_mod #(.IDX_W(IDX_W)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hdone && r_act != oaht_pkg::ACT_CLEAR),
        .i_num   (w_hash),
        .i_div   (r_n),
        .o_done  (w_mdone),
        .o_rem   (w_home)
    );

    assign w_hit = (w_rmark == oaht_pkg::MARK_LIVE) && (w_rhash == r_h) &&
                   (w_rnull == r_null) && (w_rlen == r_len) && (w_rkey == r_key);
    assign w_empty     = (w_rmark == oaht_pkg::MARK_EMPTY);
    assign w_use_dead  = r_have_dead || (w_rmark == oaht_pkg::MARK_DEAD);
    assign w_dead_slot = r_have_dead ? r_dead_at : r_idx;
    assign w_last      = (r_steps == r_n - 1'b1);
    assign w_next_wide = {1'b0, r_idx} + 1'b1;
    assign w_next      = (w_next_wide == r_n) ? '0 : w_next_wide[IDX_W-1:0];
    assign w_raddr     = (r_state == S_MOD) ? w_home : r_idx;

    oaht_store #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (w_clear),
        .o_sweeping (w_sweeping),
        .i_raddr    (w_raddr),
        .o_rmark    (w_rmark),
        .o_rkey     (w_rkey),
        .o_rlen     (w_rlen),
        .o_rnull    (w_rnull),
        .o_rhash    (w_rhash),
        .o_rvalue   (w_rvalue),
        .i_mwe      (w_mwe),
        .i_waddr    (w_waddr),
        .i_wmark    (w_wmark),
        .i_ewe      (w_ewe),
        .i_wkey     (r_key),
        .i_wlen     (r_len),
        .i_wnull    (r_null),
        .i_whash    (r_h),
        .i_vwe      (w_vwe),
        .i_wvalue   (r_val)
    );

    always_comb begin
        w_clear  = 1'b0;
        w_mwe    = 1'b0;
        w_ewe    = 1'b0;
        w_vwe    = 1'b0;
        w_waddr  = r_idx;
        w_wmark  = oaht_pkg::MARK_LIVE;
        w_fin    = 1'b0;
        w_live_n = r_live;
        w_dead_n = r_dead;
        w_rsp    = '0;
        if (r_state == S_HASH && w_hdone && r_act == oaht_pkg::ACT_CLEAR) begin
            w_clear  = 1'b1;
            w_fin    = 1'b1;
            w_live_n = '0;
            w_dead_n = '0;
        end else if (r_state == S_CHECK && (w_hit || w_empty || w_last)) begin
            w_fin     = 1'b1;
            w_rsp.found = w_hit;
            case (r_act)
                oaht_pkg::ACT_LOOKUP: begin
                    if (w_hit) w_rsp.read_value = w_rvalue;
                    else w_rsp.status = oaht_pkg::ST_NOTFOUND;
                end
                oaht_pkg::ACT_REMOVE: begin
                    if (w_hit) begin
                        w_mwe    = 1'b1;
                        w_wmark  = oaht_pkg::MARK_DEAD;
                        w_live_n = r_live - 1'b1;
                        w_dead_n = r_dead + 1'b1;
                    end else begin
                        w_rsp.status = oaht_pkg::ST_NOTFOUND;
                    end
                end
                default: begin
                    if (w_hit) begin
                        w_vwe = 1'b1;
                    end else if (w_use_dead || w_empty) begin
                        w_waddr  = w_use_dead ? w_dead_slot : r_idx;
                        w_mwe    = 1'b1;
                        w_ewe    = 1'b1;
                        w_vwe    = 1'b1;
                        w_live_n = r_live + 1'b1;
                        if (w_use_dead) w_dead_n = r_dead - 1'b1;
                    end else begin
                        w_rsp.status = oaht_pkg::ST_FULL;
                    end
                end
            endcase
        end
        w_lhs = (CNT_W+4)'({1'b0, w_live_n} + {1'b0, w_dead_n}) * (CNT_W+4)'(10);
        w_rhs = (CNT_W+4)'(r_n) * (CNT_W+4)'(7);
        w_rsp.live_count   = w_live_n;
        w_rsp.dead_count   = w_dead_n;
        w_rsp.grow_advised = (w_lhs >= w_rhs);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_HASH;
            S_HASH:  if (w_hdone) n_state = (r_act == oaht_pkg::ACT_CLEAR) ? S_OUT : S_MOD;
            S_MOD:   if (w_mdone) n_state = S_CHECK;
            S_READ:  n_state = S_CHECK;
            S_CHECK: n_state = w_fin ? S_OUT : S_READ;
            S_OUT:   if (!r_ovalid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 11'(oaht_pkg::MIN_SLOTS);
            r_live      <= '0;
            r_dead      <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) r_active <= i_cfg_wdata;
            if (w_fin) begin
                r_live <= w_live_n;
                r_dead <= w_dead_n;
            end
            if (r_state == S_OUT && (!r_ovalid || !i_out_stall)) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act  <= i_in_data.action;
            r_key  <= w_key;
            r_len  <= w_len;
            r_null <= i_in_data.key_absent;
            r_val  <= i_in_data.new_value;
            r_n    <= (IDX_W+1)'(w_n_clamp);
        end
        if (w_hdone) r_h <= w_hash;
        if (w_mdone) begin
            r_idx       <= w_home;
            r_steps     <= '0;
            r_have_dead <= 1'b0;
        end
        if (r_state == S_CHECK && !w_fin) begin
            r_idx   <= w_next;
            r_steps <= r_steps + 1'b1;
            if (w_rmark == oaht_pkg::MARK_DEAD && !r_have_dead) begin
                r_have_dead <= 1'b1;
                r_dead_at   <= r_idx;
            end
        end
        if (w_fin) r_res <= w_rsp;
        if (r_state == S_OUT && (!r_ovalid || !i_out_stall)) r_out <= r_res;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule
